// ===== rtl/core/window_filter_3x3_top_defines.svh =====
// assertion helpers for the filter rtl
`ifndef WINDOW_FILTER_3X3_TOP_DEFINES_SVH
`define WINDOW_FILTER_3X3_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WF3_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define WF3_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wf3_pkg.sv =====
package wf3_pkg;

    localparam int PIXEL_BITS   = 8;
    localparam int IMG_W_BITS   = 11;
    localparam int IMG_H_BITS   = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 768;
    localparam int MIN_SIZE     = 3;
    localparam int OUT_DEPTH    = 8;
    localparam int WIN_TAPS     = 9;
    localparam int WIN_CENTER   = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // filter modes
    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [WIN_TAPS-1:0] win_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
        logic mode;
    } item_meta_t;

endpackage

// ===== rtl/core/wf3_ram.sv =====
module wf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/wf3_ctrl.sv =====
module wf3_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wf3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  wf3_pkg::pix_t                    s_pixel_in,
    input  logic                             room_ok,
    output logic                             emit_take,
    output logic                             item_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]     item_addr,
    output wf3_pkg::pix_t                    item_px,
    output wf3_pkg::item_meta_t              item_meta,
    output logic                             clr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     clr_addr
);
    import wf3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = IMG_H_BITS;
    localparam int LIN_W = ROW_W + WD_W;
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WD_W-1:0]  width_reg, width_next;
    logic [ROW_W-1:0] height_reg, height_next;
    logic             mode_reg, mode_next;
    logic             recalc_reg, recalc_next;
    logic             clr_busy_reg, clr_busy_next;
    logic [COL_W-1:0] clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [LIN_W-1:0] in_lin_reg, in_lin_next, out_lin_reg, out_lin_next;
    logic [LIN_W-1:0] wh_reg, wh_next;

    logic [31:0]      cfg_w32;
    logic [WD_W-1:0]  w_clamped;
    logic [ROW_W-1:0] h_raw, h_clamped;
    logic [WD_W-1:0]  w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             in_col_end, in_row_end, out_col_end, out_row_end;
    logic [LIN_W-1:0] in_lin_adv, out_lin_adv;
    logic             behind, d_huge, pix_emit, drain_emit;
    logic [LIN_W:0]   wrap_sum, d_val;
    logic             acc, is_drain, emit;
    logic [COL_W-1:0] drain_addr;
    logic             row_inner, col_inner;

    // clamp register writes to the usable range
    always_comb begin
        cfg_w32 = 32'(cfg_data[IMG_W_BITS-1:0]);
        if (cfg_w32 < 32'(MIN_SIZE)) begin
            w_clamped = WD_W'(MIN_SIZE);
        end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
            w_clamped = WD_W'(MAX_WIDTH);
        end else begin
            w_clamped = WD_W'(cfg_w32);
        end
        h_raw = cfg_data[IMG_H_BITS-1:0];
        h_clamped = (h_raw < ROW_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : h_raw;
    end

    // positions and distance between input and output
    always_comb begin
        w_m1 = width_reg - 1'b1;
        h_m1 = height_reg - 1'b1;
        in_col_end  = WD_W'(in_col_reg) >= w_m1;
        in_row_end  = in_row_reg >= h_m1;
        out_col_end = WD_W'(out_col_reg) >= w_m1;
        out_row_end = out_row_reg >= h_m1;

        if (!in_col_end) begin
            in_lin_adv = in_lin_reg + 1'b1;
        end else if (in_row_end) begin
            in_lin_adv = '0;
        end else begin
            in_lin_adv = in_lin_reg - LIN_W'(in_col_reg) + LIN_W'(width_reg);
        end
        if (!out_col_end) begin
            out_lin_adv = out_lin_reg + 1'b1;
        end else if (out_row_end) begin
            out_lin_adv = '0;
        end else begin
            out_lin_adv = out_lin_reg - LIN_W'(out_col_reg) + LIN_W'(width_reg);
        end

        behind   = in_lin_reg < out_lin_reg;
        wrap_sum = {1'b0, in_lin_reg} + {1'b0, wh_reg};
        // still behind after the frame wrap: the distance is huge
        d_huge   = behind && (wrap_sum < {1'b0, out_lin_reg});
        d_val    = behind ? (wrap_sum - {1'b0, out_lin_reg})
                          : ({1'b0, in_lin_reg} - {1'b0, out_lin_reg});
        pix_emit   = d_huge || (d_val > (LIN_W+1)'(width_reg));
        drain_emit = d_huge || (d_val != '0);

        drain_addr = out_col_end ? '0 : out_col_reg + 1'b1;
        row_inner  = (out_row_reg != '0)
                  && (({1'b0, out_row_reg} + (ROW_W+1)'(2)) <= {1'b0, height_reg});
        col_inner  = (out_col_reg != '0)
                  && (((WD_W+1)'(out_col_reg) + (WD_W+1)'(2)) <= (WD_W+1)'(width_reg));
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = !clr_busy_reg && !recalc_reg && room_ok;
    assign acc       = s_valid && s_ready;
    assign is_drain  = (s_req_type == REQ_DRAIN);
    assign emit      = is_drain ? drain_emit : pix_emit;
    assign emit_take = acc && emit;

    assign item_valid         = acc && (!is_drain || drain_emit);
    assign item_addr          = is_drain ? drain_addr : in_col_reg;
    assign item_px            = is_drain ? '0 : s_pixel_in;
    assign item_meta.emit     = emit;
    assign item_meta.interior = row_inner && col_inner;
    assign item_meta.last     = out_row_end && out_col_end;
    assign item_meta.mode     = mode_reg;

    assign clr_en   = clr_busy_reg;
    assign clr_addr = clr_addr_reg;

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        mode_next     = mode_reg;
        recalc_next   = cfg_valid;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        in_lin_next   = in_lin_reg;
        out_lin_next  = out_lin_reg;
        wh_next       = wh_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = w_clamped;
                REG_IMAGE_HEIGHT: height_next = h_clamped;
                REG_FILTER_MODE:  mode_next   = cfg_data[0];
                default: ;
            endcase
        end

        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end

        // rebuild linear positions after a size change
        if (recalc_reg) begin
            in_lin_next  = LIN_W'(in_row_reg) * LIN_W'(width_reg) + LIN_W'(in_col_reg);
            out_lin_next = LIN_W'(out_row_reg) * LIN_W'(width_reg) + LIN_W'(out_col_reg);
            wh_next      = LIN_W'(height_reg) * LIN_W'(width_reg);
        end

        if (acc && !is_drain) begin
            in_lin_next = in_lin_adv;
            in_col_next = in_col_end ? '0 : in_col_reg + 1'b1;
            if (in_col_end) begin
                in_row_next = in_row_end ? '0 : in_row_reg + 1'b1;
            end
        end
        if (emit_take) begin
            out_lin_next = out_lin_adv;
            out_col_next = out_col_end ? '0 : out_col_reg + 1'b1;
            if (out_col_end) begin
                out_row_next = out_row_end ? '0 : out_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WD_W'(RST_W);
            height_reg   <= ROW_W'(RESET_HEIGHT);
            mode_reg     <= MODE_MEDIAN;
            recalc_reg   <= 1'b1;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            in_lin_reg   <= '0;
            out_lin_reg  <= '0;
            wh_reg       <= '0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            mode_reg     <= mode_next;
            recalc_reg   <= recalc_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            in_lin_reg   <= in_lin_next;
            out_lin_reg  <= out_lin_next;
            wh_reg       <= wh_next;
        end
    end

endmodule

// ===== rtl/core/wf3_win.sv =====
module wf3_win #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] clr_addr,
    input  logic                         item_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] item_addr,
    input  wf3_pkg::pix_t                item_px,
    input  wf3_pkg::item_meta_t          item_meta,
    output wf3_pkg::win_t                win,
    output logic                         tap_valid,
    output wf3_pkg::item_meta_t          tap_meta
);
    import wf3_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WORD_W = 2 * PIXEL_BITS;

    logic              v1_reg;
    logic [AW-1:0]     addr1_reg;
    pix_t              px1_reg;
    item_meta_t        meta1_reg;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [WORD_W-1:0] fwd_word_reg;
    win_t              win_reg, win_next;
    logic              tap_valid_reg;
    item_meta_t        tap_meta_reg;

    logic [WORD_W-1:0] rd_word, line_word, wr_word;
    pix_t              top_px, mid_px;

    // word layout: older row in the upper byte, newer row in the lower byte
    wf3_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (clr_en || v1_reg),
        .wr_addr (clr_en ? clr_addr : addr1_reg),
        .wr_data (clr_en ? '0 : wr_word),
        .rd_en   (item_valid),
        .rd_addr (item_addr),
        .rd_data (rd_word)
    );

    always_comb begin
        line_word = fwd_hit_reg ? fwd_word_reg : rd_word;
        top_px    = line_word[WORD_W-1 -: PIXEL_BITS];
        mid_px    = line_word[PIXEL_BITS-1:0];
        wr_word   = {mid_px, px1_reg};
        // a read that races the write-back of the same column
        fwd_hit_next = item_valid && v1_reg && (addr1_reg == item_addr);

        win_next = win_reg;
        if (v1_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]     = win_reg[r*3 + 1];
                win_next[r*3 + 1] = win_reg[r*3 + 2];
            end
            win_next[2] = top_px;
            win_next[5] = mid_px;
            win_next[8] = px1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            tap_valid_reg <= 1'b0;
            win_reg       <= '0;
        end else begin
            v1_reg        <= item_valid;
            fwd_hit_reg   <= fwd_hit_next;
            tap_valid_reg <= v1_reg && meta1_reg.emit;
            win_reg       <= win_next;
        end
        addr1_reg    <= item_addr;
        px1_reg      <= item_px;
        meta1_reg    <= item_meta;
        fwd_word_reg <= wr_word;
        tap_meta_reg <= meta1_reg;
    end

    assign win       = win_reg;
    assign tap_valid = tap_valid_reg;
    assign tap_meta  = tap_meta_reg;

endmodule

// ===== rtl/core/wf3_filter.sv =====
module wf3_filter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  wf3_pkg::item_meta_t in_meta,
    input  wf3_pkg::win_t       win,
    output logic                out_valid,
    output wf3_pkg::pix_t       out_pixel,
    output logic                out_last
);
    import wf3_pkg::*;

    localparam int SUM_W       = PIXEL_BITS + 4;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    // ceil(2^16 / 9), exact floor for sums of nine pixels
    localparam logic [RECIP_W-1:0] RECIP = 13'd7282;
    localparam int PROD_W      = SUM_W + RECIP_W;

    function automatic pix_t f_min(pix_t a, pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t f_max(pix_t a, pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t f_med3(pix_t a, pix_t b, pix_t c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    // stage a: sort each row, sum the window
    pix_t [2:0]       lo_next, md_next, hi_next;
    pix_t [2:0]       lo_reg, md_reg, hi_reg;
    logic [SUM_W-1:0] sum_next, sum_reg;
    pix_t             a_ctr_reg;
    logic             a_valid_reg;
    item_meta_t       a_meta_reg;

    // stage b: reduce across rows, scale the sum
    pix_t              mx_reg, mm_reg, mn_reg;
    logic [PROD_W-1:0] prod_reg;
    pix_t              b_ctr_reg;
    logic              b_valid_reg;
    item_meta_t        b_meta_reg;

    // stage c: final pick
    pix_t res_next, res_reg;
    logic out_valid_reg, out_last_reg;

    always_comb begin
        sum_next = '0;
        for (int r = 0; r < 3; r++) begin
            lo_next[r] = f_min(f_min(win[r*3], win[r*3 + 1]), win[r*3 + 2]);
            hi_next[r] = f_max(f_max(win[r*3], win[r*3 + 1]), win[r*3 + 2]);
            md_next[r] = f_med3(win[r*3], win[r*3 + 1], win[r*3 + 2]);
        end
        for (int i = 0; i < WIN_TAPS; i++) begin
            sum_next = sum_next + SUM_W'(win[i]);
        end
    end

    always_comb begin
        if (!b_meta_reg.interior) begin
            res_next = b_ctr_reg;
        end else if (b_meta_reg.mode == MODE_MEAN) begin
            res_next = prod_reg[RECIP_SHIFT +: PIXEL_BITS];
        end else begin
            res_next = f_med3(mx_reg, mm_reg, mn_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
        lo_reg       <= lo_next;
        md_reg       <= md_next;
        hi_reg       <= hi_next;
        sum_reg      <= sum_next;
        a_ctr_reg    <= win[WIN_CENTER];
        a_meta_reg   <= in_meta;
        mx_reg       <= f_max(f_max(lo_reg[0], lo_reg[1]), lo_reg[2]);
        mm_reg       <= f_med3(md_reg[0], md_reg[1], md_reg[2]);
        mn_reg       <= f_min(f_min(hi_reg[0], hi_reg[1]), hi_reg[2]);
        prod_reg     <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        b_ctr_reg    <= a_ctr_reg;
        b_meta_reg   <= a_meta_reg;
        res_reg      <= res_next;
        out_last_reg <= b_meta_reg.last;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = res_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/core/window_filter_3x3_top.sv =====
// channel   | handshake              | word
// ----------+------------------------+--------------------------------------
// cfg       | cfg_valid / cfg_ready  | cfg_index (2b), cfg_data (12b)
// input     | s_valid / s_ready      | s_req_type (1b), s_pixel_in (8b)
// result    | m_valid / m_ready      | m_pixel_out (8b), m_frame_end (1b)
//
// one input word per clock while s_ready is high; the result a word causes reaches
// the port through the window shift, three filter register stages and the queue write
// after reset the line ram is cleared with s_ready low
// each register write drops s_ready for one cycle to rebuild frame positions
// s_ready follows a credit count of results in flight and queued; an 8-entry
// output queue absorbs result-side stalls without blocking the input early
`include "window_filter_3x3_top_defines.svh"

module window_filter_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wf3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  wf3_pkg::pix_t                  s_pixel_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wf3_pkg::pix_t                  m_pixel_out,
    output logic                           m_frame_end
);
    import wf3_pkg::*;

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int PEND_W  = $clog2(OUT_DEPTH + 1);
    localparam int FIFO_AW = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic frame_end;
        pix_t pixel;
    } out_word_t;

    // control to line store
    logic       item_valid;
    logic [AW-1:0] item_addr;
    pix_t       item_px;
    item_meta_t item_meta;
    logic       clr_en;
    logic [AW-1:0] clr_addr;
    logic       room_ok;
    logic       emit_take;

    // line store to filter
    win_t       win;
    logic       tap_valid;
    item_meta_t tap_meta;

    // filter to output queue
    logic       filt_valid;
    pix_t       filt_pixel;
    logic       filt_last;

    // credits and output queue
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [FIFO_AW:0]   wr_ptr_reg, rd_ptr_reg;
    out_word_t          fifo_reg [OUT_DEPTH];
    out_word_t          head;
    logic               fifo_wr, fifo_full, m_take;

    // counters, register file, emission decision, ram clearing
    wf3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_pixel_in (s_pixel_in),
        .room_ok    (room_ok),
        .emit_take  (emit_take),
        .item_valid (item_valid),
        .item_addr  (item_addr),
        .item_px    (item_px),
        .item_meta  (item_meta),
        .clr_en     (clr_en),
        .clr_addr   (clr_addr)
    );

    // two line rows in one ram word plus the 3x3 window
    wf3_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr_en     (clr_en),
        .clr_addr   (clr_addr),
        .item_valid (item_valid),
        .item_addr  (item_addr),
        .item_px    (item_px),
        .item_meta  (item_meta),
        .win        (win),
        .tap_valid  (tap_valid),
        .tap_meta   (tap_meta)
    );

    // median network and mean, border pass-through
    wf3_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tap_valid),
        .in_meta   (tap_meta),
        .win       (win),
        .out_valid (filt_valid),
        .out_pixel (filt_pixel),
        .out_last  (filt_last)
    );

    // credit: every accepted emitting word holds one queue slot until taken
    assign m_take    = m_valid && m_ready;
    assign room_ok   = pend_reg < PEND_W'(OUT_DEPTH);
    assign fifo_wr   = filt_valid;
    assign fifo_full = (wr_ptr_reg[FIFO_AW] != rd_ptr_reg[FIFO_AW])
                    && (wr_ptr_reg[FIFO_AW-1:0] == rd_ptr_reg[FIFO_AW-1:0]);

    always_comb begin
        pend_next = pend_reg;
        if (emit_take && !m_take) begin
            pend_next = pend_reg + 1'b1;
        end else if (!emit_take && m_take) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            if (fifo_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (m_take) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (fifo_wr) begin
            fifo_reg[wr_ptr_reg[FIFO_AW-1:0]] <= '{frame_end: filt_last, pixel: filt_pixel};
        end
    end

    // queue head drives the result port
    assign head        = fifo_reg[rd_ptr_reg[FIFO_AW-1:0]];
    assign m_valid     = (wr_ptr_reg != rd_ptr_reg);
    assign m_pixel_out = head.pixel;
    assign m_frame_end = head.frame_end;

    `WF3_ASSERT_IMP(a_pend_bound, aclk, aresetn, 1'b1, pend_reg <= PEND_W'(OUT_DEPTH), "credit count above queue depth")
    `WF3_ASSERT_IMP(a_no_overflow, aclk, aresetn, fifo_wr, !fifo_full || m_take, "result written into full queue")
    `WF3_ASSERT_IMP(a_out_credit, aclk, aresetn, m_valid, pend_reg != '0, "result shown without a credit")
    `WF3_ASSERT_NXT(a_credit_taken, aclk, aresetn, emit_take && !m_take, pend_reg != '0, "emitting word took no credit")

endmodule

// ===== tb/window_filter_3x3_checker.sv =====
module window_filter_3x3_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wf3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_req_type,
    input  wf3_pkg::pix_t                  s_pixel_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  wf3_pkg::pix_t                  m_pixel_out,
    input  logic                           m_frame_end,
    output int                             mismatches,
    output int                             pending,
    output int                             results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import wf3_pkg::*;

    localparam int IN_POS  = 0;
    localparam int OUT_POS = 1;

    typedef struct packed {
        pix_t pixel;
        logic frame_end;
    } out_word_t;

    out_word_t expected_q [$];

    // two line buffers and the 3x3 window, row-major taps
    pix_t line_old [MAX_WIDTH];
    pix_t line_new [MAX_WIDTH];
    pix_t tap      [WIN_TAPS];

    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    logic                  mode_reg;

    int unsigned pos_col [2];
    int unsigned pos_row [2];

    function automatic int unsigned cols_used();
        int unsigned w;
        w = width_reg;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned rows_used();
        return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
    endfunction

    function automatic void advance_pos(input int which, input int unsigned w,
                                        input int unsigned h);
        if (pos_col[which] >= w - 1) begin
            pos_col[which] = 0;
            pos_row[which] = (pos_row[which] >= h - 1) ? 0 : pos_row[which] + 1;
        end else begin
            pos_col[which] = pos_col[which] + 1;
        end
    endfunction

    function automatic void push_column(input int unsigned addr, input pix_t px);
        pix_t upper;
        pix_t middle;
        int r;
        if (addr >= MAX_WIDTH) addr = 0;
        upper = line_old[addr];
        middle = line_new[addr];
        line_old[addr] = middle;
        line_new[addr] = px;
        for (r = 0; r < 3; r++) begin
            tap[r*3]   = tap[r*3+1];
            tap[r*3+1] = tap[r*3+2];
        end
        tap[2] = upper;
        tap[5] = middle;
        tap[8] = px;
    endfunction

    function automatic pix_t window_median();
        pix_t v [WIN_TAPS];
        pix_t t;
        int i;
        int j;
        for (i = 0; i < WIN_TAPS; i++) v[i] = tap[i];
        for (i = 1; i < WIN_TAPS; i++) begin
            for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
                t = v[j];
                v[j] = v[j-1];
                v[j-1] = t;
            end
        end
        return v[WIN_CENTER];
    endfunction

    function automatic pix_t window_mean();
        int unsigned total;
        int i;
        total = 0;
        for (i = 0; i < WIN_TAPS; i++) total += tap[i];
        return pix_t'(total / WIN_TAPS);
    endfunction

    function automatic void clear_filter();
        int i;
        width_reg = IMG_W_BITS'(RESET_WIDTH);
        height_reg = IMG_H_BITS'(RESET_HEIGHT);
        mode_reg = MODE_MEDIAN;
        for (i = 0; i < MAX_WIDTH; i++) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        for (i = 0; i < WIN_TAPS; i++) tap[i] = '0;
        for (i = 0; i < 2; i++) begin
            pos_col[i] = 0;
            pos_row[i] = 0;
        end
        expected_q.delete();
    endfunction

    function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        unique case (idx)
            REG_IMAGE_WIDTH: begin
                width_reg = data[IMG_W_BITS-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                height_reg = data[IMG_H_BITS-1:0];
            end
            REG_FILTER_MODE: begin
                mode_reg = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    // one accepted input word; queues the result word it releases, if any
    function automatic void filter_word(input logic req, input pix_t px);
        int unsigned w;
        int unsigned h;
        int unsigned in_lin;
        int unsigned out_lin;
        int unsigned backlog;
        int unsigned addr;
        logic emit;
        logic interior;
        out_word_t word;
        w = cols_used();
        h = rows_used();
        in_lin = pos_row[IN_POS] * w + pos_col[IN_POS];
        out_lin = pos_row[OUT_POS] * w + pos_col[OUT_POS];
        backlog = (in_lin >= out_lin) ? in_lin - out_lin : in_lin + w * h - out_lin;
        if (req == REQ_DRAIN) begin
            if (backlog == 0) return;
            addr = (pos_col[OUT_POS] >= w - 1) ? 0 : pos_col[OUT_POS] + 1;
            push_column(addr, '0);
            emit = 1'b1;
        end else begin
            emit = (backlog >= w + 1);
            push_column(pos_col[IN_POS], px);
            advance_pos(IN_POS, w, h);
        end
        if (!emit) return;
        interior = pos_row[OUT_POS] >= 1 && pos_row[OUT_POS] + 2 <= h &&
                   pos_col[OUT_POS] >= 1 && pos_col[OUT_POS] + 2 <= w;
        if (!interior) word.pixel = tap[WIN_CENTER];
        else if (mode_reg == MODE_MEAN) word.pixel = window_mean();
        else word.pixel = window_median();
        word.frame_end = pos_row[OUT_POS] >= h - 1 && pos_col[OUT_POS] >= w - 1;
        advance_pos(OUT_POS, w, h);
        expected_q.push_back(word);
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_result(input pix_t got_pixel, input logic got_end);
        out_word_t want;
        if (expected_q.size() == 0) begin
            note_failure($sformatf("result word with none expected: pixel %0d frame_end %0b",
                                   got_pixel, got_end));
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (got_pixel !== want.pixel)
            note_failure($sformatf("result %0d pixel_out expected %0d got %0d",
                                   results_checked, want.pixel, got_pixel));
        if (got_end !== want.frame_end)
            note_failure($sformatf("result %0d frame_end expected %0b got %0b",
                                   results_checked, want.frame_end, got_end));
    endfunction

    initial begin
        mismatches = 0;
        pending = 0;
        results_checked = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_filter();
        end else begin
            if (m_valid && m_ready) check_result(m_pixel_out, m_frame_end);
            if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) filter_word(s_req_type, s_pixel_in);
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wf3_pkg::*;

    localparam int LINE_MAX     = 1024;
    localparam int GAP_MAX      = 18;
    localparam int SETTLE       = 12;       // pipeline depth plus margin
    localparam int RANDOM_WORDS = 1300;
    localparam int WIDE_PIXELS  = 2 * LINE_MAX + 4;
    localparam int IN_SIDE      = 0;
    localparam int OUT_SIDE     = 1;

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    pix_t                  s_pixel_in;
    logic                  m_valid;
    logic                  m_ready;
    pix_t                  m_pixel_out;
    logic                  m_frame_end;

    int mismatches;
    int pending;
    int results_checked;

    // bookkeeping for the stimulus and the closing summary
    int unsigned cur_w;
    int unsigned cur_h;
    int          words_sent;
    int          wide_words;
    int          settings_used;
    int          calm_left [2];

    window_filter_3x3_top #(.MAX_WIDTH(LINE_MAX)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_frame_end (m_frame_end)
    );

    // watches all three channels, predicts every result word and compares
    window_filter_3x3_checker #(.MAX_WIDTH(LINE_MAX)) filter_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_frame_end     (m_frame_end),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // idle cycles before the next word on one side; now and then a calm
    // stretch with no idling at all so back-to-back traffic is covered too
    function automatic int unsigned draw_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left[side] = $urandom_range(15, 40);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // mostly random grey, with a bias toward the two extremes
    function automatic pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return pix_t'($urandom);
        endcase
    endfunction

    // all stimulus tasks start and end on a falling edge; s_valid stays high
    // on return so a zero-gap word follows without a bubble
    task automatic send_word(input logic req, input pix_t px);
        int unsigned gap;
        gap = draw_gap(IN_SIDE);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req_type = req;
        s_pixel_in = px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    // stop the input, wait for every predicted word, then let the pipeline
    // empty of words that release nothing
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // new size and mode; unused upper data bits are randomized since the
    // registers only keep their own width
    task automatic configure(input logic [IMG_W_BITS-1:0] w_raw,
                             input logic [IMG_H_BITS-1:0] h_raw, input logic mode);
        wait_idle();
        cfg_write(REG_IMAGE_WIDTH, {1'($urandom), w_raw});
        cfg_write(REG_IMAGE_HEIGHT, h_raw);
        cfg_write(REG_FILTER_MODE, {11'($urandom), mode});
        cfg_valid = 1'b0;
        cur_w = (w_raw < MIN_SIZE) ? MIN_SIZE : (w_raw > LINE_MAX) ? LINE_MAX : w_raw;
        cur_h = (h_raw < MIN_SIZE) ? MIN_SIZE : h_raw;
        settings_used++;
    endtask

    // flush the last row plus one pixel of the frame
    task automatic drain_frame();
        repeat (cur_w + 1) send_word(REQ_DRAIN, rand_pixel());
    endtask

    // one frame in raster order; a rare stray drain lands mid frame
    task automatic send_frame();
        int unsigned i;
        for (i = 0; i < cur_w * cur_h; i++) begin
            if ($urandom_range(0, 99) == 0) send_word(REQ_DRAIN, rand_pixel());
            send_word(REQ_PIXEL, rand_pixel());
        end
    endtask

    // result side: a fresh stall drawn for every word
    initial begin
        int unsigned gap;
        m_ready = 1'b0;
        do @(negedge aclk); while (!aresetn);
        forever begin
            gap = draw_gap(OUT_SIDE);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // hard stop in case the block hangs
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        pix_t corner_mix [9];
        int   start_words;
        int   frames;
        int   f;
        int   ending;
        bit   wide_done;
        bit   tall_done;
        logic [IMG_W_BITS-1:0] w_raw;
        logic [IMG_H_BITS-1:0] h_raw;

        corner_mix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255};
        wide_done = 1'b0;
        tall_done = 1'b0;
        words_sent = 0;
        wide_words = 0;
        settings_used = 0;
        calm_left[IN_SIDE] = 0;
        calm_left[OUT_SIDE] = 0;
        cur_w = RESET_WIDTH;
        cur_h = RESET_HEIGHT;

        // every input known from time zero
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        s_valid = 1'b0;
        s_req_type = REQ_PIXEL;
        s_pixel_in = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed part ----
        // a write to the unmapped index must change nothing
        cfg_write(REG_SPARE, 12'($urandom));
        cfg_valid = 1'b0;

        // smallest image, median; a drain with nothing pending releases no word
        configure(11'd3, 12'd3, MODE_MEDIAN);
        send_word(REQ_DRAIN, 8'hff);
        foreach (corner_mix[i]) send_word(REQ_PIXEL, corner_mix[i]);
        drain_frame();

        // mean of an all-white window is the largest possible sum
        configure(11'd3, 12'd3, MODE_MEAN);
        repeat (9) send_word(REQ_PIXEL, 8'hff);
        drain_frame();

        // ---- random part ----
        start_words = words_sent;
        while (words_sent - wide_words - start_words < RANDOM_WORDS) begin
            // one partial frame at the widest line: fills both line buffers
            // end to end and reaches a few interior pixels of row one
            if (!wide_done && words_sent - start_words > 400) begin
                wide_done = 1'b1;
                configure($urandom_range(0, 1) ? 11'd2047 : 11'(LINE_MAX), 12'd3,
                          1'($urandom));
                f = words_sent;
                repeat (WIDE_PIXELS) send_word(REQ_PIXEL, rand_pixel());
                wide_words = words_sent - f;
            end

            // tallest frame register, only its first rows are streamed; the
            // next size change then lands mid frame
            if (!tall_done && words_sent - start_words > 800) begin
                tall_done = 1'b1;
                configure(11'($urandom_range(3, 8)), 12'd4095, 1'($urandom));
                repeat (cur_w * 5) send_word(REQ_PIXEL, rand_pixel());
            end

            case ($urandom_range(0, 9))
                0: w_raw = 11'($urandom_range(0, 2));
                1: w_raw = 11'($urandom_range(11, 40));
                default: w_raw = 11'($urandom_range(3, 10));
            endcase
            h_raw = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                                : 12'($urandom_range(3, 6));
            configure(w_raw, h_raw, 1'($urandom));

            // back-to-back frames run on without drains
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) send_frame();

            // usually flush; sometimes an extra idle drain; sometimes leave
            // the frame open so the next setting changes the size mid stream
            ending = $urandom_range(0, 7);
            if (ending != 0) drain_frame();
            if (ending == 1) send_word(REQ_DRAIN, rand_pixel());
        end

        wait_idle();

        $display("stimulus: %0d input words (%0d in one max-width run) over %0d settings",
                 words_sent, wide_words, settings_used);
        $display("checked %0d filtered result words", results_checked);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wf3_pkg.sv
rtl/core/wf3_ram.sv
rtl/core/wf3_ctrl.sv
rtl/core/wf3_win.sv
rtl/core/wf3_filter.sv
rtl/core/window_filter_3x3_top.sv
tb/window_filter_3x3_checker.sv
tb/tb.sv
